### sv/plru_pkg.sv
// Shared types, codes and constants of the tree pseudo-LRU replacement block.
package plru_pkg;

    localparam int DEF_NUM_WAYS = 8;
    localparam int DEF_NUM_SETS = 64;

    localparam int OP_FIELD_W   = 2;
    localparam int SET_FIELD_W  = 6;
    localparam int WAY_FIELD_W  = 3;
    localparam int MASK_FIELD_W = 8;
    localparam int SET_IDX_N    = 1 << SET_FIELD_W;

    localparam int QDEPTH = 2;

    localparam logic [OP_FIELD_W-1:0] CMD_TOUCH  = 2'd0;
    localparam logic [OP_FIELD_W-1:0] CMD_INVAL  = 2'd1;
    localparam logic [OP_FIELD_W-1:0] CMD_VICTIM = 2'd2;

    typedef struct packed {
        logic [OP_FIELD_W-1:0]   operation;
        logic [SET_FIELD_W-1:0]  set_index;
        logic [WAY_FIELD_W-1:0]  way;
        logic [MASK_FIELD_W-1:0] candidate_mask;
    } plru_req_t;

    typedef struct packed {
        logic [WAY_FIELD_W-1:0] victim_way;
        logic                   no_candidate;
    } plru_res_t;

    typedef enum logic [1:0] {
        KIND_TOUCH,
        KIND_INVAL,
        KIND_VICTIM
    } plru_kind_t;

    typedef struct packed {
        plru_kind_t              kind;
        logic [SET_FIELD_W-1:0]  set_index;
        logic [WAY_FIELD_W-1:0]  way;
        logic [MASK_FIELD_W-1:0] candidate_mask;
    } plru_qent_t;

    typedef struct packed {
        logic       valid;
        plru_qent_t ent;
    } plru_qhead_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } plru_bstat_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } plru_state_t;

endpackage

### sv/plru_front.sv
// Command front end: accepts items, classifies them, queues known operations.
module plru_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  plru_pkg::plru_req_t   request,
    input  plru_pkg::plru_bstat_t bstat,
    output plru_pkg::plru_qhead_t head
);

    localparam int QPTR_W = (plru_pkg::QDEPTH > 1) ? $clog2(plru_pkg::QDEPTH) : 1;
    localparam int QCNT_W = $clog2(plru_pkg::QDEPTH + 1);

    plru_pkg::plru_qent_t q_reg [plru_pkg::QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    logic                 push;
    logic                 known;
    plru_pkg::plru_qent_t ent;

    always_comb
    begin
        known = 1'b1;
        ent.kind = plru_pkg::KIND_TOUCH;
        case (request.operation)
            plru_pkg::CMD_TOUCH:  ent.kind = plru_pkg::KIND_TOUCH;
            plru_pkg::CMD_INVAL:  ent.kind = plru_pkg::KIND_INVAL;
            plru_pkg::CMD_VICTIM: ent.kind = plru_pkg::KIND_VICTIM;
            default:              known = 1'b0;
        endcase
        ent.set_index      = request.set_index;
        ent.way            = request.way;
        ent.candidate_mask = request.candidate_mask;
    end

    assign busy = (cnt_reg == QCNT_W'(plru_pkg::QDEPTH)) || bstat.clearing;
    assign push = start && !busy && known;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(plru_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (bstat.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(plru_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !bstat.pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && bstat.pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= ent;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.ent   = q_reg[rd_ptr_reg];

endmodule

### sv/plru_back.sv
// Execution back end: holds the per-set trees and carries out queued items.
module plru_back #(
    parameter int NUM_WAYS = plru_pkg::DEF_NUM_WAYS,
    parameter int NUM_SETS = plru_pkg::DEF_NUM_SETS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  plru_pkg::plru_qhead_t head,
    output plru_pkg::plru_bstat_t bstat,
    output logic                  result_valid,
    output plru_pkg::plru_res_t   result
);

    localparam int LEVELS     = $clog2(NUM_WAYS);
    localparam int WAY_W      = LEVELS;
    localparam int TREE_W     = NUM_WAYS - 1;
    localparam int ALL_W      = 2 * NUM_WAYS - 1;
    localparam int SET_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int MASK_EXT_W = (NUM_WAYS > plru_pkg::MASK_FIELD_W) ?
                                NUM_WAYS : plru_pkg::MASK_FIELD_W;
    localparam int VW         = plru_pkg::WAY_FIELD_W;

    function automatic logic [plru_pkg::SET_IDX_N-1:0][SET_W-1:0] build_set_map();
        logic [plru_pkg::SET_IDX_N-1:0][SET_W-1:0] tbl;
        int c;
        int i;
        c = 0;
        for (i = 0; i < plru_pkg::SET_IDX_N; i++)
        begin
            tbl[i] = SET_W'(c);
            c = (c + 1 == NUM_SETS) ? 0 : c + 1;
        end
        return tbl;
    endfunction

    localparam logic [plru_pkg::SET_IDX_N-1:0][SET_W-1:0] SET_MAP = build_set_map();

    function automatic logic [TREE_W-1:0] update_path(input logic [TREE_W-1:0] bits,
                                                      input logic [WAY_W-1:0]  w,
                                                      input logic              toward);
        logic [TREE_W-1:0] res;
        int l;
        int p;
        res = bits;
        for (l = 0; l < LEVELS; l++)
        begin
            for (p = 0; p < (1 << l); p++)
            begin
                if ((int'(w) >> (LEVELS - l)) == p)
                begin
                    res[(1 << l) - 1 + p] = toward ? w[LEVELS-1-l] : !w[LEVELS-1-l];
                end
            end
        end
        return res;
    endfunction

    function automatic logic [WAY_W-1:0] pick_way(input logic [TREE_W-1:0]   bits,
                                                  input logic [NUM_WAYS-1:0] m);
        logic [ALL_W-1:0]  has;
        logic [TREE_W-1:0] go_r;
        logic [WAY_W-1:0]  v;
        logic              d;
        int k;
        int l;
        int p;
        has = '0;
        for (k = 0; k < NUM_WAYS; k++)
        begin
            has[TREE_W + k] = m[k];
        end
        for (k = TREE_W - 1; k >= 0; k--)
        begin
            has[k] = has[2*k + 1] | has[2*k + 2];
        end
        for (k = 0; k < TREE_W; k++)
        begin
            go_r[k] = !has[2*k + 1] || (has[2*k + 2] && bits[k]);
        end
        v = '0;
        for (l = 0; l < LEVELS; l++)
        begin
            d = 1'b0;
            for (p = 0; p < (1 << l); p++)
            begin
                if (int'(v) == p)
                begin
                    d = go_r[(1 << l) - 1 + p];
                end
            end
            v = (v << 1) | WAY_W'(d);
        end
        return v;
    endfunction

    logic [TREE_W-1:0] plru_mem_reg [NUM_SETS];

    plru_pkg::plru_state_t state_reg, state_next;
    logic [SET_W-1:0]      clr_cnt_reg, clr_cnt_next;
    plru_pkg::plru_qent_t  item_reg;
    logic [SET_W-1:0]      set_reg;
    logic [TREE_W-1:0]     rd_data_reg;
    logic                  result_valid_reg, result_valid_next;
    plru_pkg::plru_res_t   result_reg, result_next;

    logic                  pop;
    logic                  mem_we;
    logic [SET_W-1:0]      mem_wa;
    logic [TREE_W-1:0]     mem_wd;
    logic [SET_W-1:0]      rd_set;
    logic [WAY_W-1:0]      way_r;
    logic [MASK_EXT_W-1:0] mask_ext;
    logic [NUM_WAYS-1:0]   mask_r;
    logic [TREE_W-1:0]     upd_bits;
    logic [WAY_W-1:0]      vic_way;
    logic                  empty;

    assign rd_set   = SET_MAP[head.ent.set_index];
    assign way_r    = WAY_W'(item_reg.way);
    assign mask_ext = MASK_EXT_W'(item_reg.candidate_mask);
    assign mask_r   = mask_ext[NUM_WAYS-1:0];
    assign upd_bits = update_path(rd_data_reg, way_r, item_reg.kind == plru_pkg::KIND_INVAL);
    assign vic_way  = pick_way(rd_data_reg, mask_r);
    assign empty    = (mask_r == '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plru_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = plru_pkg::ST_IDLE;
                end
            end
            plru_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = plru_pkg::ST_EXEC;
                end
            end
            plru_pkg::ST_EXEC:
            begin
                state_next = plru_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = plru_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop               = 1'b0;
        mem_we            = 1'b0;
        mem_wa            = set_reg;
        mem_wd            = upd_bits;
        clr_cnt_next      = clr_cnt_reg;
        result_valid_next = 1'b0;
        result_next.victim_way   = empty ? '0 : VW'(vic_way);
        result_next.no_candidate = empty;
        bstat.clearing    = 1'b0;
        case (state_reg)
            plru_pkg::ST_CLEAR:
            begin
                bstat.clearing = 1'b1;
                mem_we         = 1'b1;
                mem_wa         = clr_cnt_reg;
                mem_wd         = '0;
                clr_cnt_next   = clr_cnt_reg + 1'b1;
            end
            plru_pkg::ST_IDLE:
            begin
                pop = head.valid;
            end
            plru_pkg::ST_EXEC:
            begin
                if (item_reg.kind == plru_pkg::KIND_VICTIM)
                begin
                    result_valid_next = 1'b1;
                end
                else
                begin
                    mem_we = 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
        bstat.pop = pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= plru_pkg::ST_CLEAR;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head.ent;
            set_reg  <= rd_set;
        end
        if (result_valid_next)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            plru_mem_reg[mem_wa] <= mem_wd;
        end
        if (pop)
        begin
            rd_data_reg <= plru_mem_reg[rd_set];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### sv/tree_plru_replacement.sv
// Top level of the tree pseudo-LRU replacement block.
//
// An item is taken when start is high and busy is low; a two-entry queue sits
// between the command front end and the execution unit, so up to two items can
// be taken while another is being carried out. In the execution unit each item
// first has its set's tree read from the tree memory and then has the updated
// tree written back or its victim formed. A victim result shows on result for
// one cycle with result_valid high, registered from that victim step, and it
// cannot be held off. After reset the tree memory is cleared one set per cycle,
// and busy stays high until that is done.
module tree_plru_replacement #(
    parameter int NUM_WAYS = plru_pkg::DEF_NUM_WAYS,
    parameter int NUM_SETS = plru_pkg::DEF_NUM_SETS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  plru_pkg::plru_req_t request,
    output logic                result_valid,
    output plru_pkg::plru_res_t result
);

    plru_pkg::plru_qhead_t head;
    plru_pkg::plru_bstat_t bstat;

    plru_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .bstat   (bstat),
        .head    (head)
    );

    plru_back #(
        .NUM_WAYS (NUM_WAYS),
        .NUM_SETS (NUM_SETS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .bstat        (bstat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### sv/plru_checker.sv
// Port-level assertions for the tree pseudo-LRU replacement block, with its bind.
module plru_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input plru_pkg::plru_req_t request,
    input logic                result_valid,
    input plru_pkg::plru_res_t result
);

    logic [2:0] pend_reg, pend_next;
    logic       vic_acc;

    assign vic_acc = start && !busy && (request.operation == plru_pkg::CMD_VICTIM);

    always_comb
    begin
        pend_next = pend_reg;
        if (vic_acc && !result_valid)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!vic_acc && result_valid)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("Results were delivered in consecutive cycles.");

    a_empty_way_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.no_candidate) |-> (result.victim_way == '0))
        else $error("Victim way is not zero for an empty candidate mask.");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pend_reg != '0))
        else $error("A result appeared with no victim item outstanding.");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd3)
        else $error("More victim items outstanding than the block can hold.");

endmodule

bind tree_plru_replacement plru_checker u_plru_checker (.*);

### dv/tb_tree_plru_replacement.sv
// Testbench for the tree pseudo-LRU replacement block: directed table, then random items.
`timescale 1ns / 1ps

module tb_tree_plru_replacement;

    localparam int NWAYS = plru_pkg::DEF_NUM_WAYS;
    localparam int NSETS = plru_pkg::DEF_NUM_SETS;
    localparam logic [plru_pkg::OP_FIELD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS = 550;
    localparam int NUM_DIRECTED = 18;

    typedef struct packed {
        plru_pkg::plru_req_t req;
        logic                typed;
        plru_pkg::plru_res_t res;
    } table_row_t;

    localparam table_row_t DIRECTED [NUM_DIRECTED] = '{
        '{'{plru_pkg::CMD_VICTIM, 6'd0,  3'd0, 8'hff}, 1'b1, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_VICTIM, 6'd63, 3'd7, 8'h00}, 1'b1, '{3'd0, 1'b1}},
        '{'{plru_pkg::CMD_VICTIM, 6'd5,  3'd0, 8'h80}, 1'b1, '{3'd7, 1'b0}},
        '{'{plru_pkg::CMD_VICTIM, 6'd5,  3'd7, 8'h01}, 1'b1, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_TOUCH,  6'd0,  3'd0, 8'h00}, 1'b0, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_VICTIM, 6'd0,  3'd0, 8'hff}, 1'b0, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_TOUCH,  6'd0,  3'd7, 8'hff}, 1'b0, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_VICTIM, 6'd0,  3'd7, 8'hff}, 1'b0, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_INVAL,  6'd0,  3'd5, 8'h00}, 1'b0, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_VICTIM, 6'd0,  3'd0, 8'hff}, 1'b0, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_VICTIM, 6'd0,  3'd0, 8'h81}, 1'b0, '{3'd0, 1'b0}},
        '{'{CMD_UNUSED,           6'd63, 3'd7, 8'hff}, 1'b0, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_TOUCH,  6'd63, 3'd7, 8'h00}, 1'b0, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_INVAL,  6'd63, 3'd0, 8'hff}, 1'b0, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_VICTIM, 6'd63, 3'd3, 8'hff}, 1'b0, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_VICTIM, 6'd63, 3'd0, 8'h3c}, 1'b0, '{3'd0, 1'b0}},
        '{'{plru_pkg::CMD_VICTIM, 6'd63, 3'd0, 8'h00}, 1'b1, '{3'd0, 1'b1}},
        '{'{plru_pkg::CMD_VICTIM, 6'd62, 3'd0, 8'h40}, 1'b1, '{3'd6, 1'b0}}
    };

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    plru_pkg::plru_req_t request;
    logic                result_valid;
    plru_pkg::plru_res_t result;

    logic [NWAYS-2:0]    plru_tree [NSETS];
    plru_pkg::plru_res_t expected_victims [$];
    int                  err_count;
    int                  cycle_count;
    int                  idle_pct;

    tree_plru_replacement u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void update_path(int set_idx, int way_idx, bit toward);
        int node;
        int parent;
        node = way_idx + NWAYS - 1;
        while (node != 0)
        begin
            parent = (node - 1) / 2;
            plru_tree[set_idx][parent] = toward ? (node % 2 == 0) : (node % 2 != 0);
            node = parent;
        end
    endfunction

    function automatic logic [plru_pkg::WAY_FIELD_W-1:0] choose_victim(
        logic [NWAYS-2:0] bits,
        logic [NWAYS-1:0] mask);
        bit has [2*NWAYS-1];
        int i;
        int node;
        for (i = 0; i < 2*NWAYS-1; i++)
            has[i] = 1'b0;
        for (i = 0; i < NWAYS; i++)
            has[i + NWAYS - 1] = mask[i];
        for (i = 2*NWAYS-2; i > 0; i--)
            if (has[i])
                has[(i - 1) / 2] = 1'b1;
        node = 0;
        while (node < NWAYS - 1)
        begin
            if (!has[2*node + 1])
                node = 2*node + 2;
            else if (!has[2*node + 2])
                node = 2*node + 1;
            else
                node = bits[node] ? 2*node + 2 : 2*node + 1;
        end
        return plru_pkg::WAY_FIELD_W'(node - (NWAYS - 1));
    endfunction

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_item(plru_pkg::plru_req_t req, logic typed,
                             plru_pkg::plru_res_t typed_res);
        plru_pkg::plru_res_t exp_res;
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do @(posedge clk); while (busy);
        case (req.operation)
            plru_pkg::CMD_TOUCH:  update_path(req.set_index % NSETS, req.way % NWAYS, 1'b0);
            plru_pkg::CMD_INVAL:  update_path(req.set_index % NSETS, req.way % NWAYS, 1'b1);
            plru_pkg::CMD_VICTIM:
            begin
                if (req.candidate_mask[NWAYS-1:0] == '0)
                    exp_res = '{victim_way: '0, no_candidate: 1'b1};
                else
                    exp_res = '{victim_way: choose_victim(plru_tree[req.set_index % NSETS],
                                                          req.candidate_mask[NWAYS-1:0]),
                                no_candidate: 1'b0};
                expected_victims.push_back(typed ? typed_res : exp_res);
            end
            default: ;
        endcase
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge clk); while (expected_victims.size() != 0);
    endtask

    always @(posedge clk)
    begin
        plru_pkg::plru_res_t exp_res;
        if (rst_n && result_valid)
        begin
            if (expected_victims.size() == 0)
            begin
                $error("unexpected result: victim_way %0d no_candidate %0d",
                       result.victim_way, result.no_candidate);
                err_count++;
            end
            else
            begin
                exp_res = expected_victims.pop_front();
                if (result.victim_way !== exp_res.victim_way)
                begin
                    $error("victim_way: expected %0d, actual %0d",
                           exp_res.victim_way, result.victim_way);
                    err_count++;
                end
                if (result.no_candidate !== exp_res.no_candidate)
                begin
                    $error("no_candidate: expected %0d, actual %0d",
                           exp_res.no_candidate, result.no_candidate);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        plru_pkg::plru_req_t req;
        int phase;
        int n;
        int r;
        err_count   = 0;
        cycle_count = 0;
        idle_pct    = 0;
        for (n = 0; n < NSETS; n++)
            plru_tree[n] = '0;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < NUM_DIRECTED; n++)
            send_item(DIRECTED[n].req, DIRECTED[n].typed, DIRECTED[n].res);
        wait_for_results();

        for (phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 30 : (phase == 1) ? 61 : 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                req.operation = (r < 35) ? plru_pkg::CMD_TOUCH :
                                (r < 50) ? plru_pkg::CMD_INVAL :
                                (r < 95) ? plru_pkg::CMD_VICTIM : CMD_UNUSED;
                req.set_index = plru_pkg::SET_FIELD_W'($urandom_range(0, 1) ?
                                    $urandom_range(0, 3) :
                                    $urandom_range(0, plru_pkg::SET_IDX_N - 1));
                req.way = plru_pkg::WAY_FIELD_W'($urandom_range(0, 7));
                r = $urandom_range(0, 9);
                if (r == 0)
                    req.candidate_mask = 8'h00;
                else if (r == 1)
                    req.candidate_mask = 8'hff;
                else if (r < 4)
                    req.candidate_mask = 8'h01 << $urandom_range(0, 7);
                else if (r == 4)
                    req.candidate_mask = (8'h01 << $urandom_range(0, 7))
                                       | (8'h01 << $urandom_range(0, 7));
                else
                    req.candidate_mask = plru_pkg::MASK_FIELD_W'($urandom_range(0, 255));
                send_item(req, 1'b0, '0);
                if ($urandom_range(0, 199) == 0)
                    wait_for_results();
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && expected_victims.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
